>>> hw/rtl/max_flow_edmonds_karp_assert.svh
// assertion macros for the rtl
`ifndef MAX_FLOW_EDMONDS_KARP_ASSERT_SVH
`define MAX_FLOW_EDMONDS_KARP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MFEK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfek assertion failed");

// next-cycle implication, disabled in reset
`define MFEK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfek assertion failed");

`endif

>>> hw/rtl/mfek_pkg.sv
`default_nettype none
package mfek_pkg;

  localparam int TOTAL_BITS = 22;
  localparam int NODE_FIELD_BITS = 6;
  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_QUEUED = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

endpackage
`default_nettype wire

>>> hw/rtl/max_flow_edmonds_karp.sv
`default_nettype none
// Edmonds-Karp max flow engine. A beat is taken when start is high and busy is low, and a run
// result appears on total_flow/request_error for exactly one cycle with done high; the receiver
// cannot stall it. A capacity write leaves busy low, so writes stream back to back. A matrix
// clear, and the clearing pass after reset, sweep the capacity memory one entry a cycle with
// busy high. A bad run request answers in the next cycle. A run first clears the flow memory,
// then per search clears the marks and seeds the queue, dequeues nodes until it finds the queue
// empty, and scans the row of each dequeued node with one memory read and one evaluate per
// neighbor; a found path is walked once for its minimum and once more for the update, all bound
// by the one read port of each memory. The result comes out in the cycle after the last search
// finds no path.
module max_flow_edmonds_karp
  import mfek_pkg::*;
#(
  parameter int MAX_NODE_COUNT = 64,
  parameter int CAP_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 func,
  input  wire logic [NODE_FIELD_BITS-1:0] from_node,
  input  wire logic [NODE_FIELD_BITS-1:0] to_node,
  input  wire logic [15:0]                capacity_value,
  input  wire logic [NODE_FIELD_BITS-1:0] source_node,
  input  wire logic [NODE_FIELD_BITS-1:0] sink_node,
  output logic                            done,
  output logic [TOTAL_BITS-1:0]           total_flow,
  output logic                            request_error,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_BITS-1:0]        cfg_wr_data
);

  localparam int NB = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
  localparam int NCW = NB + 1;
  localparam int CELLS = MAX_NODE_COUNT * MAX_NODE_COUNT;
  localparam int AW = $clog2(CELLS);
  localparam int FW = CAP_BITS + 2;
  localparam int RW = CAP_BITS + 3;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [3:0] {
    CLR_CAP, IDLE, CLR_FLOW, BFS_INIT, BFS_PUSH, DEQ, DEQ_WAIT, SCAN_RD, SCAN_EV,
    WALK_PRED, WALK_PW, WALK_EV, AUG_PRED, AUG_PW, AUG_W1, AUG_W2
  } state_t;

  function automatic logic [AW-1:0] entry_addr(input logic [NB-1:0] r, input logic [NB-1:0] c);
    entry_addr = AW'(32'(r) * MAX_NODE_COUNT + 32'(c));
  endfunction

  state_t state;
  logic [AW-1:0] cnt;
  logic [NB-1:0] u, v, s, t;
  logic [NCW-1:0] head, tail;
  logic found, first;
  logic signed [RW-1:0] m;
  logic [TOTAL_BITS-1:0] total;
  logic [CFG_BITS-1:0] node_count;

  logic cap_we, flow_we, mark_we, pred_we, q_we;
  logic [AW-1:0] cap_waddr, cap_raddr, flow_waddr, flow_raddr;
  logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
  logic [FW-1:0] flow_wdata, flow_rdata;
  logic [NB-1:0] mark_waddr, mark_raddr, pred_waddr, pred_raddr, q_waddr, q_raddr;
  logic [1:0] mark_wdata, mark_rdata;
  logic [NB-1:0] pred_wdata, pred_rdata, q_wdata, q_rdata;

  logic accept, wr_ok, run_err, push;
  logic [NCW-1:0] n_cur;
  logic [NB-1:0] last_v;
  logic signed [RW-1:0] res;

  assign busy = (state != IDLE);
  assign accept = start && !busy;
  assign wr_ok = (32'(from_node) < MAX_NODE_COUNT) && (32'(to_node) < MAX_NODE_COUNT);

  always_comb begin
    if (node_count < 7'd2) begin
      n_cur = NCW'(2);
    end else if (32'(node_count) > MAX_NODE_COUNT) begin
      n_cur = NCW'(MAX_NODE_COUNT);
    end else begin
      n_cur = NCW'(node_count);
    end
  end

  assign last_v = NB'(n_cur - NCW'(1));
  assign run_err = (source_node == sink_node) || (32'(source_node) >= 32'(n_cur)) ||
                   (32'(sink_node) >= 32'(n_cur));
  assign res = $signed({{(RW-CAP_BITS){1'b0}}, cap_rdata}) -
               $signed({flow_rdata[FW-1], flow_rdata});
  assign push = (mark_rdata == MARK_NONE) && (res > 0);

  always_comb begin
    cap_we = 1'b0;
    cap_waddr = cnt;
    cap_wdata = '0;
    cap_raddr = entry_addr(u, v);
    flow_we = 1'b0;
    flow_waddr = cnt;
    flow_wdata = '0;
    flow_raddr = entry_addr(u, v);
    mark_we = 1'b0;
    mark_waddr = v;
    mark_wdata = MARK_NONE;
    mark_raddr = v;
    pred_we = 1'b0;
    pred_waddr = v;
    pred_wdata = u;
    pred_raddr = v;
    q_we = 1'b0;
    q_waddr = tail[NB-1:0];
    q_wdata = v;
    q_raddr = head[NB-1:0];
    unique case (state)
      CLR_CAP: cap_we = 1'b1;
      IDLE: begin
        if (accept && func == FUNC_WRITE && wr_ok) begin
          cap_we = 1'b1;
          cap_waddr = entry_addr(NB'(from_node), NB'(to_node));
          cap_wdata = CAP_BITS'(capacity_value);
        end
      end
      CLR_FLOW: flow_we = 1'b1;
      BFS_INIT: mark_we = 1'b1;
      BFS_PUSH: begin
        mark_we = 1'b1;
        mark_waddr = s;
        mark_wdata = MARK_QUEUED;
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = s;
      end
      DEQ_WAIT: begin
        mark_we = 1'b1;
        mark_waddr = q_rdata;
        mark_wdata = MARK_DONE;
      end
      SCAN_EV: begin
        if (push) begin
          mark_we = 1'b1;
          mark_wdata = MARK_QUEUED;
          q_we = 1'b1;
          pred_we = 1'b1;
        end
      end
      WALK_PW: begin
        cap_raddr = entry_addr(pred_rdata, v);
        flow_raddr = entry_addr(pred_rdata, v);
      end
      AUG_PW: flow_raddr = entry_addr(pred_rdata, v);
      AUG_W1: begin
        flow_we = 1'b1;
        flow_waddr = entry_addr(u, v);
        flow_wdata = flow_rdata + FW'(m);
        flow_raddr = entry_addr(v, u);
      end
      AUG_W2: begin
        flow_we = 1'b1;
        flow_waddr = entry_addr(v, u);
        flow_wdata = flow_rdata - FW'(m);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR_CAP;
      cnt <= '0;
      node_count <= NODE_COUNT_RESET;
      done <= 1'b0;
      head <= '0;
      tail <= '0;
      total <= '0;
      found <= 1'b0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      unique case (state)
        CLR_CAP: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST_CELL) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            case (func)
              FUNC_RUN: begin
                if (run_err) begin
                  done <= 1'b1;
                  total_flow <= '0;
                  request_error <= 1'b1;
                end else begin
                  s <= NB'(source_node);
                  t <= NB'(sink_node);
                  cnt <= '0;
                  state <= CLR_FLOW;
                end
              end
              FUNC_CLEAR: begin
                cnt <= '0;
                state <= CLR_CAP;
              end
              default: begin
              end
            endcase
          end
        end
        CLR_FLOW: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST_CELL) begin
            total <= '0;
            v <= '0;
            state <= BFS_INIT;
          end
        end
        BFS_INIT: begin
          if (v == last_v) begin
            state <= BFS_PUSH;
          end else begin
            v <= v + NB'(1);
          end
        end
        BFS_PUSH: begin
          head <= '0;
          tail <= NCW'(1);
          found <= 1'b0;
          state <= DEQ;
        end
        DEQ: begin
          if (head == tail) begin
            if (found) begin
              v <= t;
              first <= 1'b1;
              state <= WALK_PRED;
            end else begin
              done <= 1'b1;
              total_flow <= total;
              request_error <= 1'b0;
              state <= IDLE;
            end
          end else begin
            state <= DEQ_WAIT;
          end
        end
        DEQ_WAIT: begin
          u <= q_rdata;
          head <= head + NCW'(1);
          v <= '0;
          state <= SCAN_RD;
        end
        SCAN_RD: state <= SCAN_EV;
        SCAN_EV: begin
          if (push) begin
            tail <= tail + NCW'(1);
            if (v == t) begin
              found <= 1'b1;
            end
          end
          if (v == last_v) begin
            state <= DEQ;
          end else begin
            v <= v + NB'(1);
            state <= SCAN_RD;
          end
        end
        WALK_PRED: state <= WALK_PW;
        WALK_PW: begin
          u <= pred_rdata;
          state <= WALK_EV;
        end
        WALK_EV: begin
          if (first || res < m) begin
            m <= res;
          end
          first <= 1'b0;
          if (u == s) begin
            v <= t;
            state <= AUG_PRED;
          end else begin
            v <= u;
            state <= WALK_PRED;
          end
        end
        AUG_PRED: state <= AUG_PW;
        AUG_PW: begin
          u <= pred_rdata;
          state <= AUG_W1;
        end
        AUG_W1: state <= AUG_W2;
        AUG_W2: begin
          if (u == s) begin
            total <= total + TOTAL_BITS'(m);
            v <= '0;
            state <= BFS_INIT;
          end else begin
            v <= u;
            state <= AUG_PRED;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  mfek_ram #(.WIDTH(CAP_BITS), .DEPTH(CELLS)) u_cap_ram (
    .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rdata)
  );

  mfek_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
    .raddr(flow_raddr), .rdata(flow_rdata)
  );

  mfek_ram #(.WIDTH(2), .DEPTH(MAX_NODE_COUNT)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  mfek_ram #(.WIDTH(NB), .DEPTH(MAX_NODE_COUNT)) u_pred_ram (
    .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
    .raddr(pred_raddr), .rdata(pred_rdata)
  );

  mfek_ram #(.WIDTH(NB), .DEPTH(MAX_NODE_COUNT)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

`include "max_flow_edmonds_karp_assert.svh"

  `MFEK_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy) || $past(start))
  `MFEK_ASSERT_NOW(a_error_zero, clk, rst, done && request_error, total_flow == '0)
  `MFEK_ASSERT_NEXT(a_run_engages, clk, rst, accept && func == FUNC_RUN, busy || done)
  `MFEK_ASSERT_NOW(a_queue_order, clk, rst, state == DEQ, head <= tail)

endmodule
`default_nettype wire

>>> hw/rtl/mfek_ram.sv
`default_nettype none
module mfek_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfek_pkg::*;

  class flow_scoreboard;
    typedef struct {
      bit [TOTAL_BITS-1:0] flow;
      bit                  err;
    } flow_result_t;

    bit [15:0]          cap_mem [4096];
    int                 flow_mem [4096];
    bit [CFG_BITS-1:0]  node_cfg = NODE_COUNT_RESET;
    flow_result_t       flow_q [$];
    int mismatches, run_count, bad_runs, write_count, clear_count;

    function int active_nodes();
      if (node_cfg < 2) return 2;
      if (node_cfg > 64) return 64;
      return int'(node_cfg);
    endfunction

    function int resid(int u, int v);
      return int'(cap_mem[u*64+v]) - flow_mem[u*64+v];
    endfunction

    function void note_item(bit [1:0] fn, bit [5:0] a, bit [5:0] b, bit [15:0] c,
                            bit [5:0] s, bit [5:0] t);
      int n, head, tail, u, v, steps, path_min, total;
      bit [1:0] mark [64];
      int pred [64];
      int fifo [64];
      flow_result_t r;
      n = active_nodes();
      case (fn)
        FUNC_WRITE: begin
          cap_mem[int'({a, b})] = c;
          write_count++;
        end
        FUNC_CLEAR: begin
          foreach (cap_mem[i]) cap_mem[i] = '0;
          clear_count++;
        end
        FUNC_RUN: begin
          run_count++;
          if (s == t || s >= n || t >= n) begin
            r.flow = '0;
            r.err = 1'b1;
            bad_runs++;
          end else begin
            foreach (flow_mem[i]) flow_mem[i] = 0;
            total = 0;
            forever begin
              for (u = 0; u < n; u++) mark[u] = MARK_NONE;
              head = 0;
              tail = 1;
              fifo[0] = s;
              mark[s] = MARK_QUEUED;
              pred[s] = s;
              while (head != tail) begin
                u = fifo[head];
                head++;
                mark[u] = MARK_DONE;
                for (v = 0; v < n; v++) begin
                  if (mark[v] == MARK_NONE && resid(u, v) > 0) begin
                    if (tail < 64) begin
                      fifo[tail] = v;
                      tail++;
                    end
                    mark[v] = MARK_QUEUED;
                    pred[v] = u;
                  end
                end
              end
              if (mark[t] != MARK_DONE) break;
              path_min = 1000000000;
              for (v = t, steps = 0; v != s && steps < n; v = u, steps++) begin
                u = pred[v];
                if (resid(u, v) < path_min) path_min = resid(u, v);
              end
              for (v = t, steps = 0; v != s && steps < n; v = u, steps++) begin
                u = pred[v];
                flow_mem[u*64+v] += path_min;
                flow_mem[v*64+u] -= path_min;
              end
              total = (total + path_min) & 32'h3f_ffff;
            end
            r.flow = total[TOTAL_BITS-1:0];
            r.err = 1'b0;
          end
          flow_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [TOTAL_BITS-1:0] flow, bit err);
      flow_result_t r;
      if (flow_q.size() == 0) begin
        $error("result with nothing expected: total_flow %0d request_error %0d", flow, err);
        mismatches++;
        return;
      end
      r = flow_q.pop_front();
      if (flow !== r.flow) begin
        $error("total_flow expected %0d actual %0d", r.flow, flow);
        mismatches++;
      end
      if (err !== r.err) begin
        $error("request_error expected %0d actual %0d", r.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [1:0]                 func;
  logic [NODE_FIELD_BITS-1:0] from_node;
  logic [NODE_FIELD_BITS-1:0] to_node;
  logic [15:0]                capacity_value;
  logic [NODE_FIELD_BITS-1:0] source_node;
  logic [NODE_FIELD_BITS-1:0] sink_node;
  logic                       done;
  logic [TOTAL_BITS-1:0]      total_flow;
  logic                       request_error;
  logic                       cfg_wr_en;
  logic [CFG_BITS-1:0]        cfg_wr_data;

  flow_scoreboard sb = new();
  int idle_pct;
  int beats;

  max_flow_edmonds_karp dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .from_node(from_node), .to_node(to_node), .capacity_value(capacity_value),
    .source_node(source_node), .sink_node(sink_node), .done(done),
    .total_flow(total_flow), .request_error(request_error),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(total_flow, request_error);
  end

  task automatic send_item(bit [1:0] fn, bit [5:0] a, bit [5:0] b, bit [15:0] c,
                           bit [5:0] s, bit [5:0] t);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= fn;
    from_node <= a;
    to_node <= b;
    capacity_value <= c;
    source_node <= s;
    sink_node <= t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(fn, a, b, c, s, t);
    if (fn != FUNC_UNUSED) beats++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.flow_q.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_nodes(bit [CFG_BITS-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.node_cfg = val;
  endtask

  task automatic random_set();
    int r, eff, k, runs, a, b;
    r = $urandom_range(99);
    if (r < 70) set_nodes(CFG_BITS'($urandom_range(8, 2)));
    else if (r < 90) set_nodes(CFG_BITS'($urandom_range(20, 9)));
    else if (r < 96) set_nodes(CFG_BITS'($urandom_range(127)));
    else set_nodes(CFG_BITS'(64));
    eff = sb.active_nodes();
    if ($urandom_range(3) == 0) send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom),
                                          16'($urandom), 6'($urandom), 6'($urandom));
    k = $urandom_range(3 * eff, 2);
    if (k > 40) k = 40;
    repeat (k) begin
      a = $urandom_range(eff - 1);
      b = $urandom_range(eff - 1);
      if ($urandom_range(9) == 0) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end
      r = $urandom_range(7);
      send_item(FUNC_WRITE, 6'(a), 6'(b),
                r == 0 ? 16'hffff : r == 1 ? 16'h0 : r < 4 ? 16'($urandom_range(20)) :
                16'($urandom), 6'($urandom), 6'($urandom));
      if ($urandom_range(19) == 0) send_item(FUNC_UNUSED, 6'($urandom), 6'($urandom),
                                             16'($urandom), 6'($urandom), 6'($urandom));
    end
    runs = $urandom_range(3, 1);
    repeat (runs) begin
      a = $urandom_range(eff - 1);
      b = $urandom_range(eff - 1);
      if ($urandom_range(5) == 0) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end
      send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom), 6'(a), 6'(b));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_WRITE;
    from_node = '0;
    to_node = '0;
    capacity_value = '0;
    source_node = '0;
    sink_node = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_pct = 21;
    beats = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_item(FUNC_RUN, 0, 0, 0, 0, 63);
    send_item(FUNC_WRITE, 0, 63, 16'hffff, 0, 0);
    send_item(FUNC_WRITE, 63, 0, 16'h0001, 0, 0);
    send_item(FUNC_RUN, 0, 0, 0, 0, 63);
    send_item(FUNC_RUN, 0, 0, 0, 63, 0);
    send_item(FUNC_RUN, 0, 0, 0, 5, 5);
    send_item(FUNC_UNUSED, 6'h3f, 6'h3f, 16'hffff, 6'h3f, 6'h3f);
    set_nodes(CFG_BITS'(0));
    send_item(FUNC_RUN, 0, 0, 0, 0, 1);
    send_item(FUNC_WRITE, 0, 1, 16'hffff, 0, 0);
    send_item(FUNC_RUN, 0, 0, 0, 0, 1);
    send_item(FUNC_RUN, 0, 0, 0, 0, 2);
    send_item(FUNC_RUN, 0, 0, 0, 63, 1);
    set_nodes(CFG_BITS'(127));
    send_item(FUNC_CLEAR, 0, 0, 0, 0, 0);
    send_item(FUNC_WRITE, 0, 1, 10, 0, 0);
    send_item(FUNC_WRITE, 0, 2, 10, 0, 0);
    send_item(FUNC_WRITE, 1, 2, 1, 0, 0);
    send_item(FUNC_WRITE, 1, 3, 10, 0, 0);
    send_item(FUNC_WRITE, 2, 3, 10, 0, 0);
    send_item(FUNC_RUN, 0, 0, 0, 0, 3);
    send_item(FUNC_RUN, 0, 0, 0, 3, 0);

    // random, three idling phases
    while (beats < 450) begin
      idle_pct = beats < 170 ? 21 : beats < 320 ? 76 : 0;
      random_set();
    end

    wait_drained();
    repeat (5000) @(posedge clk);
    $display("covered %0d beats: %0d writes, %0d clears, %0d runs (%0d rejected)",
             beats, sb.write_count, sb.clear_count, sb.run_count, sb.bad_runs);
    if (sb.mismatches == 0 && sb.flow_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
